@@ design/isg_pkg.sv @@
`default_nettype none

package isg_pkg;

	// Depth of the two small queues (front to back, back to result port)
	localparam int unsigned QUEUE_DEPTH = 2;

	// Opcodes of an input request
	localparam logic OP_OFFER  = 1'b0;
	localparam logic OP_RESYNC = 1'b1;

	// Raw bits of IEEE negative zero, folded onto positive zero
	localparam logic [63:0] NEG_ZERO_BITS = 64'h8000_0000_0000_0000;

	typedef enum logic [2:0] {
		ST_ACCEPTED      = 3'd0,
		ST_EMPTY         = 3'd1,
		ST_DUPLICATE     = 3'd2,
		ST_BAD_GEN       = 3'd3,
		ST_STALE         = 3'd4,
		ST_RESYNC        = 3'd5,
		ST_RESET_OK      = 3'd6,
		ST_RESET_REFUSED = 3'd7
	} status_t;

	// Request after decode, as queued between front and back
	typedef struct packed {
		logic        is_resync;
		logic        resync_refused;
		logic        is_empty;
		logic        well_formed;
		logic [63:0] generation;
		logic [63:0] first_seq;
		logic [63:0] last_seq;
		logic [63:0] next_seq;
		logic [63:0] time_bits;
		logic [63:0] hash;
	} item_t;

endpackage

`default_nettype wire

@@ design/isg_fifo.sv @@
`default_nettype none

module isg_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Store a request at the write pointer
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + CNT_W'(1);
				2'b01: count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ design/isg_front.sv @@
`default_nettype none

module isg_front
	import isg_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        opcode,
	input  wire logic [63:0] generation,
	input  wire logic [63:0] first_sequence,
	input  wire logic [63:0] last_sequence,
	input  wire logic        is_empty,
	input  wire logic [63:0] target_time_bits,
	input  wire logic [63:0] batch_hash,
	input  wire logic        well_formed,
	output logic             avail,
	input  wire logic        take,
	output item_t            item
);

	localparam int unsigned ITEM_W = $bits(item_t);

	item_t             dec;
	logic [ITEM_W-1:0] q_rdata;
	logic              q_empty;

	// Classify the request and work out everything that needs no gate state
	always_comb begin
		dec.is_resync      = (opcode == OP_RESYNC);
		dec.resync_refused = (generation == '0) || (first_sequence == '0);
		dec.is_empty       = is_empty;
		dec.well_formed    = well_formed;
		dec.generation     = generation;
		dec.first_seq      = first_sequence;
		dec.last_seq       = last_sequence;
		dec.next_seq       = last_sequence + 64'd1;
		dec.time_bits      = (target_time_bits == NEG_ZERO_BITS) ? '0 : target_time_bits;
		dec.hash           = batch_hash;
	end

	// Hold decoded requests until the back end takes them
	isg_fifo #(
		.WIDTH(ITEM_W),
		.DEPTH(DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (dec),
		.full  (full),
		.pop   (take),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	assign avail = !q_empty;
	assign item  = item_t'(q_rdata);

endmodule

`default_nettype wire

@@ design/isg_back.sv @@
`default_nettype none

module isg_back
	import isg_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  avail,
	input  wire item_t item,
	output logic       take,
	output logic       out_push,
	output status_t    out_status,
	input  wire logic  out_full
);

	logic [63:0] cur_gen_q;
	logic [63:0] next_exp_q;
	logic [63:0] last_first_q;
	logic [63:0] last_last_q;
	logic [63:0] last_hash_q;
	logic [63:0] last_time_q;
	logic        has_acc_q;
	logic        needs_resync_q;

	logic        time_back;
	logic        set_resync;
	logic        upd_time;
	logic        upd_batch;
	logic        do_resync;

	// Take a request whenever the result queue has room
	assign take     = avail && !out_full;
	assign out_push = take;

	assign time_back = has_acc_q && (item.time_bits < last_time_q);

	// Decide the status of the request at the head
	always_comb begin
		out_status = ST_RESYNC;
		set_resync = 1'b0;
		upd_time   = 1'b0;
		upd_batch  = 1'b0;
		do_resync  = 1'b0;
		if (item.is_resync) begin
			if (item.resync_refused) begin
				out_status = ST_RESET_REFUSED;
			end else begin
				out_status = ST_RESET_OK;
				do_resync  = 1'b1;
			end
		end else if (item.generation != cur_gen_q) begin
			out_status = ST_BAD_GEN;
		end else if (needs_resync_q) begin
			out_status = ST_RESYNC;
		end else if (!item.well_formed) begin
			set_resync = 1'b1;
		end else if (item.is_empty) begin
			if (time_back) begin
				set_resync = 1'b1;
			end else begin
				out_status = ST_EMPTY;
				upd_time   = 1'b1;
			end
		end else if (item.first_seq == next_exp_q) begin
			if (time_back) begin
				set_resync = 1'b1;
			end else begin
				out_status = ST_ACCEPTED;
				upd_time   = 1'b1;
				upd_batch  = 1'b1;
			end
		end else if ((item.first_seq == last_first_q) && (item.last_seq == last_last_q)) begin
			if (item.hash == last_hash_q) begin
				out_status = ST_DUPLICATE;
			end else begin
				set_resync = 1'b1;
			end
		end else if (item.last_seq < last_first_q) begin
			out_status = ST_STALE;
		end else begin
			set_resync = 1'b1;
		end
	end

	// Update gate state on each request taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_gen_q      <= '0;
			next_exp_q     <= '0;
			last_first_q   <= '0;
			last_last_q    <= '0;
			last_hash_q    <= '0;
			last_time_q    <= '0;
			has_acc_q      <= 1'b0;
			needs_resync_q <= 1'b0;
		end else if (take) begin
			if (do_resync) begin
				cur_gen_q      <= item.generation;
				next_exp_q     <= item.first_seq;
				last_first_q   <= '0;
				last_last_q    <= '0;
				last_hash_q    <= '0;
				last_time_q    <= '0;
				has_acc_q      <= 1'b0;
				needs_resync_q <= 1'b0;
			end
			if (set_resync) begin
				needs_resync_q <= 1'b1;
			end
			if (upd_time) begin
				last_time_q <= item.time_bits;
				has_acc_q   <= 1'b1;
			end
			if (upd_batch) begin
				next_exp_q   <= item.next_seq;
				last_first_q <= item.first_seq;
				last_last_q  <= item.last_seq;
				last_hash_q  <= item.hash;
			end
		end
	end

endmodule

`default_nettype wire

@@ design/input_batch_sequence_gate.sv @@
// Admission gate for numbered input batches.
// Input side is a queue: drive a request with push while full is low; each
// request is an offer of a batch (opcode 0) or a resync (opcode 1).
// Result side is a queue: while empty is low, status holds the oldest result;
// raise pop to take it. Every request gives exactly one status, in order.
// Throughput: one request per cycle, sustained while pop keeps up.
// Path: a status appears once its request has been registered in the front
// queue and then in the result queue. The back end checks the gate state
// combinationally and updates it on the edge that takes the request, which
// is what lets a request follow the previous one at once.
// Both queues hold QUEUE_DEPTH_P entries. When pop stays low the result queue
// fills, the back end stops, the front queue fills and full rises; nothing
// is dropped and requests resume as soon as results are taken.
// Reset clears both queues and the gate state: generation, expected sequence
// and history all zero, no resync pending.
`default_nettype none

module input_batch_sequence_gate
	import isg_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        opcode,
	input  wire logic [63:0] generation,
	input  wire logic [63:0] first_sequence,
	input  wire logic [63:0] last_sequence,
	input  wire logic        is_empty,
	input  wire logic [63:0] target_time_bits,
	input  wire logic [63:0] batch_hash,
	input  wire logic        well_formed,
	output logic             empty,
	input  wire logic        pop,
	output logic [2:0]       status
);

	localparam int unsigned STATUS_W = $bits(status_t);

	item_t               mid_item;
	logic                mid_avail;
	logic                mid_take;
	logic                out_push;
	logic                out_full;
	status_t             out_status;
	logic [STATUS_W-1:0] out_wdata;

	// Accept and classify requests
	isg_front #(
		.DEPTH(QUEUE_DEPTH_P)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.opcode          (opcode),
		.generation      (generation),
		.first_sequence  (first_sequence),
		.last_sequence   (last_sequence),
		.is_empty        (is_empty),
		.target_time_bits(target_time_bits),
		.batch_hash      (batch_hash),
		.well_formed     (well_formed),
		.avail           (mid_avail),
		.take            (mid_take),
		.item            (mid_item)
	);

	// Check requests against the gate state
	isg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (mid_avail),
		.item      (mid_item),
		.take      (mid_take),
		.out_push  (out_push),
		.out_status(out_status),
		.out_full  (out_full)
	);

	assign out_wdata = out_status;

	// Hold results until the receiver pops them
	isg_fifo #(
		.WIDTH(STATUS_W),
		.DEPTH(QUEUE_DEPTH_P)
	) u_result_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.wdata (out_wdata),
		.full  (out_full),
		.pop   (pop),
		.rdata (status),
		.empty (empty)
	);

`ifndef NO_ASSERTIONS
	// Never write a result into a full result queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result written while result queue full");

	// Back end must not idle while work and room are both present
	a_back_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(mid_avail && !out_full) |-> mid_take)
		else $error("back end stalled with request and room");

	// A request into idle queues shows its status once it has passed both queues
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && !mid_avail && empty) |-> ##2 !empty)
		else $error("status missing two cycles after request");
`endif

endmodule

`default_nettype wire
